@@ hdl/sagp_pkg.sv @@
// Shared types, constants and step functions for the spatial gain and pan pipeline.
package sagp_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LISTENER_X   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LISTENER_Y   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LISTENER_Z   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_X      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_Z      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_VOLUME = 3'd5;

    localparam logic signed [15:0] RIGHT_X_RESET = 16'sd32767;
    localparam logic [15:0] MASTER_RESET = 16'd26214;

    localparam logic [15:0] UNIT_Q15     = 16'd32768;
    localparam logic [16:0] MAX_DIST_Q8  = 17'd40960;
    localparam logic [15:0] HALF_DIST_Q8 = 16'd3584;
    localparam logic [50:0] MAX_DIST_SQ  = 51'd1677721600;
    localparam logic [50:0] NEAR_SQ      = 51'd65536;
    localparam logic [14:0] GAIN_MAX     = 15'd32767;
    localparam logic [9:0]  PITCH_MIN    = 10'd128;
    localparam logic [9:0]  PITCH_MAX    = 10'd512;
    localparam logic [9:0]  PITCH_UNITY  = 10'd256;

    localparam int SQRT_STAGES = 8;
    localparam int DIV_STAGES  = 8;

    typedef struct packed {
        logic [17:0] rem;
        logic [15:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [19:0] rem;
        logic [15:0] quo;
    } div_t;

    typedef struct packed {
        logic        positional;
        logic        audible;
        logic        pan_en;
        logic        neg;
        logic [9:0]  pitch;
        logic [14:0] flat_gain;
    } side_t;

    function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] pair);
        logic [19:0] rem_sh;
        logic [19:0] trial;
        sqrt_t       nxt;
        rem_sh = {cur.rem, pair};
        trial  = {2'b00, cur.root, 2'b01};
        if (rem_sh >= trial) begin
            nxt.rem  = 18'(rem_sh - trial);
            nxt.root = {cur.root[14:0], 1'b1};
        end else begin
            nxt.rem  = rem_sh[17:0];
            nxt.root = {cur.root[14:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic div_t div_step(input div_t cur, input logic b, input logic [19:0] dvs);
        logic [20:0] rem_sh;
        div_t        nxt;
        rem_sh = {cur.rem, b};
        if (rem_sh >= {1'b0, dvs}) begin
            nxt.rem = 20'(rem_sh - {1'b0, dvs});
            nxt.quo = {cur.quo[14:0], 1'b1};
        end else begin
            nxt.rem = rem_sh[19:0];
            nxt.quo = {cur.quo[14:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

@@ hdl/spatial_audio_gain_pan.sv @@
// Top level: pipelined distance attenuation, stereo pan and pitch clamp per trigger item.
// One item enters per cycle while the output is not stalled.
// The depth comes from two 8-stage square root chains and an 8-stage pair of dividers.
// A stalled output holds the whole pipeline; s_ready is high while the output register is empty or m_ready is high.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
module spatial_audio_gain_pan
    import sagp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [23:0]            cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic signed [23:0]     s_source_x,
    input  logic signed [23:0]     s_source_y,
    input  logic signed [23:0]     s_source_z,
    input  logic signed [15:0]     s_volume,
    input  logic [15:0]            s_pitch,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_audible,
    output logic [14:0]            m_voice_gain,
    output logic [15:0]            m_left_coeff,
    output logic [15:0]            m_right_coeff,
    output logic [9:0]             m_pitch_ratio
);

    logic signed [23:0] listener_x_reg, listener_y_reg, listener_z_reg;
    logic signed [15:0] right_x_reg, right_z_reg;
    logic [15:0]        master_volume_reg;

    logic en;

    logic                s0_vld_reg;
    logic signed [24:0]  dx0_reg, dy0_reg, dz0_reg;
    logic [14:0]         vol0_reg;
    logic [15:0]         mst0_reg;
    logic [9:0]          pitch0_reg;
    logic                pos0_reg;
    logic signed [24:0]  dx_next, dy_next, dz_next;
    logic [9:0]          pitch_next;

    logic                s1_vld_reg;
    logic [48:0]         sqx1_reg, sqy1_reg, sqz1_reg;
    logic signed [40:0]  dpx1_reg, dpz1_reg;
    logic [30:0]         vm1_reg;
    logic [9:0]          pitch1_reg;
    logic                pos1_reg;
    logic signed [49:0]  sqx_next, sqy_next, sqz_next;
    logic signed [40:0]  dpx_next, dpz_next;
    logic [30:0]         vm_next;

    logic [SQRT_STAGES:0] d_vld_reg;
    sqrt_t               d_sq_reg   [0:SQRT_STAGES];
    logic [31:0]         d_rad_reg  [0:SQRT_STAGES-1];
    logic signed [41:0]  d_dot_reg  [0:SQRT_STAGES];
    logic [30:0]         d_vm_reg   [0:SQRT_STAGES];
    side_t               d_side_reg [0:SQRT_STAGES];
    sqrt_t               d_sq_next  [0:SQRT_STAGES-1];
    logic [50:0]         ssum_next;
    logic signed [41:0]  dot_next;
    logic [31:0]         flat_next;
    side_t               side2_next;

    logic                m1_vld_reg;
    logic [49:0]         m1_gprod_reg;
    logic [17:0]         m1_e_reg;
    logic [35:0]         m1_pn_reg;
    logic [18:0]         m1_pd_reg;
    side_t               m1_side_reg;
    logic [15:0]         dist_d;
    logic [16:0]         dist_left;
    logic [19:0]         k_next;
    logic [41:0]         dot_mag;

    logic [DIV_STAGES:0] v_vld_reg;
    div_t                v_dg_reg   [0:DIV_STAGES];
    div_t                v_dp_reg   [0:DIV_STAGES];
    logic [15:0]         v_gl_reg   [0:DIV_STAGES-1];
    logic [15:0]         v_pl_reg   [0:DIV_STAGES-1];
    logic [19:0]         v_e_reg    [0:DIV_STAGES-1];
    logic [19:0]         v_pd_reg   [0:DIV_STAGES-1];
    side_t               v_side_reg [0:DIV_STAGES];
    div_t                v_dg_next  [0:DIV_STAGES-1];
    div_t                v_dp_next  [0:DIV_STAGES-1];
    logic [50:0]         gm_full;

    logic [SQRT_STAGES:0] c_vld_reg;
    sqrt_t               c_l_reg    [0:SQRT_STAGES];
    sqrt_t               c_r_reg    [0:SQRT_STAGES];
    logic [31:0]         c_al_reg   [0:SQRT_STAGES-1];
    logic [31:0]         c_ar_reg   [0:SQRT_STAGES-1];
    logic [14:0]         c_gain_reg [0:SQRT_STAGES];
    side_t               c_side_reg [0:SQRT_STAGES];
    sqrt_t               c_l_next   [0:SQRT_STAGES-1];
    sqrt_t               c_r_next   [0:SQRT_STAGES-1];
    logic [15:0]         qg, qp;
    logic [14:0]         gain_next;
    logic [16:0]         pm_next, argl_next, argr_next;

    logic                out_vld_reg;
    logic                out_audible_reg;
    logic [14:0]         out_gain_reg;
    logic [15:0]         out_left_reg, out_right_reg;
    logic [9:0]          out_pitch_reg;
    sqrt_t               fl, fr;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listener_x_reg    <= '0;
            listener_y_reg    <= '0;
            listener_z_reg    <= '0;
            right_x_reg       <= RIGHT_X_RESET;
            right_z_reg       <= '0;
            master_volume_reg <= MASTER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LISTENER_X:    listener_x_reg    <= signed'(cfg_wdata);
                CFG_LISTENER_Y:    listener_y_reg    <= signed'(cfg_wdata);
                CFG_LISTENER_Z:    listener_z_reg    <= signed'(cfg_wdata);
                CFG_RIGHT_X:       right_x_reg       <= signed'(cfg_wdata[15:0]);
                CFG_RIGHT_Z:       right_z_reg       <= signed'(cfg_wdata[15:0]);
                CFG_MASTER_VOLUME: master_volume_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            d_vld_reg   <= '0;
            m1_vld_reg  <= 1'b0;
            v_vld_reg   <= '0;
            c_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg  <= s_valid;
            s1_vld_reg  <= s0_vld_reg;
            d_vld_reg   <= {d_vld_reg[SQRT_STAGES-1:0], s1_vld_reg};
            m1_vld_reg  <= d_vld_reg[SQRT_STAGES];
            v_vld_reg   <= {v_vld_reg[DIV_STAGES-1:0], m1_vld_reg};
            c_vld_reg   <= {c_vld_reg[SQRT_STAGES-1:0], v_vld_reg[DIV_STAGES]};
            out_vld_reg <= c_vld_reg[SQRT_STAGES];
        end
    end

    // Stage 0: offsets from the listener and input clamps.
    assign dx_next = s_source_x - listener_x_reg;
    assign dy_next = s_source_y - listener_y_reg;
    assign dz_next = s_source_z - listener_z_reg;

    always_comb begin
        if (s_pitch < 16'(PITCH_MIN)) begin
            pitch_next = PITCH_MIN;
        end else if (s_pitch > 16'(PITCH_MAX)) begin
            pitch_next = PITCH_MAX;
        end else begin
            pitch_next = s_pitch[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx0_reg    <= dx_next;
            dy0_reg    <= dy_next;
            dz0_reg    <= dz_next;
            vol0_reg   <= s_volume[15] ? 15'd0 : s_volume[14:0];
            mst0_reg   <= (master_volume_reg > UNIT_Q15) ? UNIT_Q15 : master_volume_reg;
            pitch0_reg <= pitch_next;
            pos0_reg   <= s_func;
        end
    end

    // Stage 1: squares, dot product terms and volume times master.
    assign sqx_next = dx0_reg * dx0_reg;
    assign sqy_next = dy0_reg * dy0_reg;
    assign sqz_next = dz0_reg * dz0_reg;
    assign dpx_next = dx0_reg * right_x_reg;
    assign dpz_next = dz0_reg * right_z_reg;
    assign vm_next  = vol0_reg * mst0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx1_reg   <= sqx_next[48:0];
            sqy1_reg   <= sqy_next[48:0];
            sqz1_reg   <= sqz_next[48:0];
            dpx1_reg   <= dpx_next;
            dpz1_reg   <= dpz_next;
            vm1_reg    <= vm_next;
            pitch1_reg <= pitch0_reg;
            pos1_reg   <= pos0_reg;
        end
    end

    // Stage 2: squared distance, range tests and flat gain.
    assign ssum_next = 51'(sqx1_reg) + 51'(sqy1_reg) + 51'(sqz1_reg);
    assign dot_next  = dpx1_reg + dpz1_reg;
    assign flat_next = 32'(vm1_reg) + 32'd16384;

    always_comb begin
        side2_next.positional = pos1_reg;
        side2_next.audible    = !pos1_reg || (ssum_next <= MAX_DIST_SQ);
        side2_next.pan_en     = pos1_reg && (ssum_next > NEAR_SQ);
        side2_next.neg        = dot_next[41];
        side2_next.pitch      = pitch1_reg;
        side2_next.flat_gain  = flat_next[29:15];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_sq_reg[0]   <= '0;
            d_rad_reg[0]  <= ssum_next[31:0];
            d_dot_reg[0]  <= dot_next;
            d_vm_reg[0]   <= vm1_reg;
            d_side_reg[0] <= side2_next;
        end
    end

    // Distance square root, two result bits per stage.
    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_dsqrt
        assign d_sq_next[j] = sqrt_step(sqrt_step(d_sq_reg[j], d_rad_reg[j][31-4*j -: 2]),
                                        d_rad_reg[j][29-4*j -: 2]);
        always_ff @(posedge aclk) begin
            if (en) begin
                d_sq_reg[j+1]   <= d_sq_next[j];
                d_dot_reg[j+1]  <= d_dot_reg[j];
                d_vm_reg[j+1]   <= d_vm_reg[j];
                d_side_reg[j+1] <= d_side_reg[j];
            end
        end
        if (j < SQRT_STAGES - 1) begin : g_rad
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_rad_reg[j+1] <= d_rad_reg[j];
                end
            end
        end
    end

    // Stage M1: attenuation product and divider operands.
    assign dist_d    = d_sq_reg[SQRT_STAGES].root;
    assign dist_left = MAX_DIST_Q8 - {1'b0, dist_d};
    assign k_next    = 20'(dist_left) * 20'd7;
    assign dot_mag   = d_dot_reg[SQRT_STAGES][41] ? 42'(-d_dot_reg[SQRT_STAGES])
                                                  : 42'(d_dot_reg[SQRT_STAGES]);

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_gprod_reg <= 50'(d_vm_reg[SQRT_STAGES]) * 50'(k_next);
            m1_e_reg     <= 18'((18'(HALF_DIST_Q8) + 18'(dist_d)) * 18'd5);
            m1_pn_reg    <= 36'(dot_mag) * 36'd7 + 36'(dist_d) * 36'd5;
            m1_pd_reg    <= 19'(dist_d) * 19'd10;
            m1_side_reg  <= d_side_reg[SQRT_STAGES];
        end
    end

    // Stage M2: rounding offset for the gain and divider start values.
    assign gm_full = 51'(m1_gprod_reg) + (51'(m1_e_reg) << 18);

    always_ff @(posedge aclk) begin
        if (en) begin
            v_dg_reg[0]   <= '{rem: 20'(gm_full[50:35]), quo: 16'd0};
            v_gl_reg[0]   <= gm_full[34:19];
            v_dp_reg[0]   <= '{rem: m1_pn_reg[35:16], quo: 16'd0};
            v_pl_reg[0]   <= m1_pn_reg[15:0];
            v_e_reg[0]    <= 20'(m1_e_reg);
            v_pd_reg[0]   <= 20'(m1_pd_reg);
            v_side_reg[0] <= m1_side_reg;
        end
    end

    // Gain and pan dividers, two quotient bits per stage.
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        assign v_dg_next[j] = div_step(div_step(v_dg_reg[j], v_gl_reg[j][15-2*j], v_e_reg[j]),
                                       v_gl_reg[j][14-2*j], v_e_reg[j]);
        assign v_dp_next[j] = div_step(div_step(v_dp_reg[j], v_pl_reg[j][15-2*j], v_pd_reg[j]),
                                       v_pl_reg[j][14-2*j], v_pd_reg[j]);
        always_ff @(posedge aclk) begin
            if (en) begin
                v_dg_reg[j+1]   <= v_dg_next[j];
                v_dp_reg[j+1]   <= v_dp_next[j];
                v_side_reg[j+1] <= v_side_reg[j];
            end
        end
        if (j < DIV_STAGES - 1) begin : g_ops
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_gl_reg[j+1] <= v_gl_reg[j];
                    v_pl_reg[j+1] <= v_pl_reg[j];
                    v_e_reg[j+1]  <= v_e_reg[j];
                    v_pd_reg[j+1] <= v_pd_reg[j];
                end
            end
        end
    end

    // Stage F: gain select, pan clamp and coefficient radicands.
    assign qg = v_dg_reg[DIV_STAGES].quo;
    assign qp = v_dp_reg[DIV_STAGES].quo;

    always_comb begin
        if (!v_side_reg[DIV_STAGES].audible) begin
            gain_next = '0;
        end else if (!v_side_reg[DIV_STAGES].positional) begin
            gain_next = v_side_reg[DIV_STAGES].flat_gain;
        end else if (qg > 16'(GAIN_MAX)) begin
            gain_next = GAIN_MAX;
        end else begin
            gain_next = qg[14:0];
        end

        if (!v_side_reg[DIV_STAGES].pan_en) begin
            pm_next = '0;
        end else if (qp > UNIT_Q15) begin
            pm_next = 17'(UNIT_Q15);
        end else begin
            pm_next = 17'(qp);
        end

        if (v_side_reg[DIV_STAGES].neg) begin
            argl_next = 17'(UNIT_Q15) + pm_next;
            argr_next = 17'(UNIT_Q15) - pm_next;
        end else begin
            argl_next = 17'(UNIT_Q15) - pm_next;
            argr_next = 17'(UNIT_Q15) + pm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_l_reg[0]    <= '0;
            c_r_reg[0]    <= '0;
            c_al_reg[0]   <= {1'b0, argl_next, 14'd0};
            c_ar_reg[0]   <= {1'b0, argr_next, 14'd0};
            c_gain_reg[0] <= gain_next;
            c_side_reg[0] <= v_side_reg[DIV_STAGES];
        end
    end

    // Coefficient square roots, two result bits per stage.
    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_csqrt
        assign c_l_next[j] = sqrt_step(sqrt_step(c_l_reg[j], c_al_reg[j][31-4*j -: 2]),
                                       c_al_reg[j][29-4*j -: 2]);
        assign c_r_next[j] = sqrt_step(sqrt_step(c_r_reg[j], c_ar_reg[j][31-4*j -: 2]),
                                       c_ar_reg[j][29-4*j -: 2]);
        always_ff @(posedge aclk) begin
            if (en) begin
                c_l_reg[j+1]    <= c_l_next[j];
                c_r_reg[j+1]    <= c_r_next[j];
                c_gain_reg[j+1] <= c_gain_reg[j];
                c_side_reg[j+1] <= c_side_reg[j];
            end
        end
        if (j < SQRT_STAGES - 1) begin : g_arg
            always_ff @(posedge aclk) begin
                if (en) begin
                    c_al_reg[j+1] <= c_al_reg[j];
                    c_ar_reg[j+1] <= c_ar_reg[j];
                end
            end
        end
    end

    // Output register with round-to-nearest on the coefficients.
    assign fl = c_l_reg[SQRT_STAGES];
    assign fr = c_r_reg[SQRT_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            out_audible_reg <= c_side_reg[SQRT_STAGES].audible;
            out_gain_reg    <= c_gain_reg[SQRT_STAGES];
            if (c_side_reg[SQRT_STAGES].audible) begin
                out_left_reg  <= fl.root + 16'(fl.rem > {2'b00, fl.root});
                out_right_reg <= fr.root + 16'(fr.rem > {2'b00, fr.root});
                out_pitch_reg <= c_side_reg[SQRT_STAGES].pitch;
            end else begin
                out_left_reg  <= '0;
                out_right_reg <= '0;
                out_pitch_reg <= PITCH_UNITY;
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_audible     = out_audible_reg;
    assign m_voice_gain  = out_gain_reg;
    assign m_left_coeff  = out_left_reg;
    assign m_right_coeff = out_right_reg;
    assign m_pitch_ratio = out_pitch_reg;

endmodule

@@ hdl/sagp_checker.sv @@
// Port-level checker for the spatial gain and pan block, bound to the top level.
module sagp_checker
    import sagp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_audible,
    input logic [14:0] m_voice_gain,
    input logic [15:0] m_left_coeff,
    input logic [15:0] m_right_coeff,
    input logic [9:0]  m_pitch_ratio
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_audible) && $stable(m_voice_gain)
            && $stable(m_left_coeff) && $stable(m_right_coeff) && $stable(m_pitch_ratio))
        else $error("A stalled result item changed.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("Input stalled without a stalled result item.");

    a_mute: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_audible |-> m_voice_gain == 15'd0 && m_left_coeff == 16'd0
            && m_right_coeff == 16'd0 && m_pitch_ratio == PITCH_UNITY)
        else $error("An inaudible item carries nonzero gain or pan.");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_audible |-> m_pitch_ratio >= PITCH_MIN && m_pitch_ratio <= PITCH_MAX
            && m_left_coeff <= UNIT_Q15 && m_right_coeff <= UNIT_Q15)
        else $error("An audible item is out of range.");

endmodule

bind spatial_audio_gain_pan sagp_checker u_sagp_checker (.*);
